// ----- sv/i2a_pkg.sv -----
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants for the ascii digit converter
// Formats, converter states, the queued job record and the digit to
// ascii mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

   // operand width actually used and digit buffer depth
   localparam int VALUE_WIDTH = 64;
   localparam int MAX_DIGITS  = 20;

   // fixed port widths
   localparam int REQ_DATA_W  = 64;
   localparam int REQ_USER_W  = 2;
   localparam int CHAR_W      = 8;

   // derived widths
   localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
   localparam int BIT_W       = $clog2(VALUE_WIDTH + 1);
   localparam int RSP_DATA_W  = 8 * ((CHAR_W + CNT_W + 7) / 8);
   localparam int HEX_W       = 4 * ((VALUE_WIDTH + 3) / 4);
   localparam int NIBBLES     = HEX_W / 4;
   localparam int HEX32_W     = 32;

   // ascii offsets: '0', 'A' - 10, 'a' - 10
   localparam logic [CHAR_W-1:0] ASCII_ZERO       = 8'd48;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_BASE = 8'd55;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_BASE = 8'd87;

   typedef logic [3:0] digit_type;

   typedef enum logic [1:0] {
      FMT_DEC      = 2'd0,
      FMT_HEX32_LO = 2'd1,
      FMT_HEX32_UP = 2'd2,
      FMT_HEX64_LO = 2'd3
   } fmt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DABBLE,
      ST_SCAN,
      ST_EMIT
   } conv_state_type;

   // one classified conversion job
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      fmt_type                fmt;
   } job_type;

   // digit value to ascii character
   function automatic logic [CHAR_W-1:0] digit_ascii(input digit_type d, input logic upper);
      logic [CHAR_W-1:0] d_ext;
      d_ext = {{(CHAR_W-4){1'b0}}, d};
      if (d < 4'd10) begin
         return ASCII_ZERO + d_ext;
      end else if (upper) begin
         return ASCII_UPPER_BASE + d_ext;
      end else begin
         return ASCII_LOWER_BASE + d_ext;
      end
   endfunction

endpackage

`default_nettype wire

// ----- sv/i2a_front.sv -----
// ----------------------------------------------------------------------------
// i2a_front: input side of the ascii digit converter
// Accepts request transfers, masks the operand for its format and holds
// the jobs in a two-entry queue for the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [i2a_pkg::REQ_DATA_W-1:0]    req_tdata,  // [63:0] value
   input  wire logic [i2a_pkg::REQ_USER_W-1:0]    req_tuser,  // [1:0] opcode
   output logic                                   job_valid,
   input  wire logic                              job_ready,
   output i2a_pkg::job_type                       job
);

   localparam int VW = i2a_pkg::VALUE_WIDTH;
   localparam logic [VW-1:0] HEX32_MASK = VW'({i2a_pkg::HEX32_W{1'b1}});

   i2a_pkg::job_type job_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   i2a_pkg::job_type job_new;
   logic             push;
   logic             pop;

   // classify: keep the used width, low 32 bits for the 32-bit hex formats
   always_comb begin
      job_new.fmt   = i2a_pkg::fmt_type'(req_tuser);
      job_new.value = req_tdata[VW-1:0];
      if (job_new.fmt == i2a_pkg::FMT_HEX32_LO || job_new.fmt == i2a_pkg::FMT_HEX32_UP) begin
         job_new.value = req_tdata[VW-1:0] & HEX32_MASK;
      end
   end

   // queue control
   assign req_tready = (fill_ff != 2'd2);
   assign job_valid  = (fill_ff != 2'd0);
   assign job        = job_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = job_valid && job_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wr_ptr_ff] <= job_new;
      end
   end

endmodule

`default_nettype wire

// ----- sv/i2a_back.sv -----
// ----------------------------------------------------------------------------
// i2a_back: digit engine of the ascii digit converter
// Builds the digits by bit-serial double dabble (decimal) or a nibble
// load (hex), skips leading zeros and sends one character per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              job_valid,
   output logic                                   job_ready,
   input  wire i2a_pkg::job_type                  job,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [i2a_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // [7:0] digit_char,
                                                              // [12:8] digit_count
   output logic                                   rsp_tlast   // last_digit
);

   localparam int VW  = i2a_pkg::VALUE_WIDTH;
   localparam int MD  = i2a_pkg::MAX_DIGITS;
   localparam int CW  = i2a_pkg::CNT_W;
   localparam int BW  = i2a_pkg::BIT_W;

   i2a_pkg::conv_state_type state_ff, state_in;
   logic [VW-1:0]           shift_ff, shift_in;
   i2a_pkg::digit_type      digits_ff [MD];
   i2a_pkg::digit_type      digits_in [MD];
   logic [BW-1:0]           bits_ff, bits_in;
   logic [CW-1:0]           remain_ff, remain_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic                    upper_ff, upper_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [i2a_pkg::CHAR_W-1:0] char_ff, char_in;
   logic                    last_ff, last_in;
   logic [CW-1:0]           cnt_out_ff, cnt_out_in;

   i2a_pkg::digit_type      adj [MD];
   i2a_pkg::digit_type      dab [MD];
   i2a_pkg::digit_type      up [MD];
   i2a_pkg::digit_type      hex [MD];
   logic                    dab_carry;
   logic                    hex_ovf;
   logic [i2a_pkg::HEX_W-1:0] hex_src;
   logic                    out_free;
   logic                    is_last;

   // one double dabble step: add 3 to digits of 5 or more, shift in the next bit
   always_comb begin
      for (int i = 0; i < MD; i++) begin
         adj[i] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
      dab[0] = {adj[0][2:0], shift_ff[VW-1]};
      for (int i = 1; i < MD; i++) begin
         dab[i] = {adj[i][2:0], adj[i-1][3]};
      end
      dab_carry = adj[MD-1][3];
   end

   // digit shift toward the top, used for zero skipping and emission
   always_comb begin
      up[0] = 4'd0;
      for (int i = 1; i < MD; i++) begin
         up[i] = digits_ff[i-1];
      end
   end

   // hex digits straight from the nibbles; nibbles above the buffer only flag overflow
   always_comb begin
      hex_src = i2a_pkg::HEX_W'(job.value);
      hex_ovf = 1'b0;
      for (int i = 0; i < MD; i++) begin
         hex[i] = 4'd0;
      end
      for (int i = 0; i < MD && i < i2a_pkg::NIBBLES; i++) begin
         hex[i] = hex_src[4*i +: 4];
      end
      for (int i = MD; i < i2a_pkg::NIBBLES; i++) begin
         hex_ovf = hex_ovf | (hex_src[4*i +: 4] != 4'd0);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_last  = (remain_ff == CW'(1));

   // sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      digits_in    = digits_ff;
      bits_in      = bits_ff;
      remain_in    = remain_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      upper_in     = upper_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      cnt_out_in   = cnt_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      job_ready    = 1'b0;

      unique case (state_ff)
         i2a_pkg::ST_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               upper_in  = (job.fmt == i2a_pkg::FMT_HEX32_UP);
               remain_in = CW'(MD);
               if (job.fmt == i2a_pkg::FMT_DEC) begin
                  for (int i = 0; i < MD; i++) begin
                     digits_in[i] = 4'd0;
                  end
                  shift_in = job.value;
                  bits_in  = BW'(VW);
                  ovf_in   = 1'b0;
                  state_in = i2a_pkg::ST_DABBLE;
               end else begin
                  digits_in = hex;
                  ovf_in    = hex_ovf;
                  state_in  = i2a_pkg::ST_SCAN;
               end
            end
         end
         i2a_pkg::ST_DABBLE: begin
            digits_in = dab;
            shift_in  = shift_ff << 1;
            ovf_in    = ovf_ff | dab_carry;
            bits_in   = bits_ff - BW'(1);
            if (bits_ff == BW'(1)) begin
               state_in = i2a_pkg::ST_SCAN;
            end
         end
         i2a_pkg::ST_SCAN: begin
            // drop leading zeros, always keep the last digit
            if (!ovf_ff && digits_ff[MD-1] == 4'd0 && !is_last) begin
               digits_in = up;
               remain_in = remain_ff - CW'(1);
            end else begin
               count_in = remain_ff;
               state_in = i2a_pkg::ST_EMIT;
            end
         end
         i2a_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = i2a_pkg::digit_ascii(digits_ff[MD-1], upper_ff);
               last_in      = is_last;
               cnt_out_in   = is_last ? count_ff : CW'(0);
               digits_in    = up;
               remain_in    = remain_ff - CW'(1);
               if (is_last) begin
                  state_in = i2a_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = i2a_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2a_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      digits_ff  <= digits_in;
      bits_ff    <= bits_in;
      remain_ff  <= remain_in;
      count_ff   <= count_in;
      ovf_ff     <= ovf_in;
      upper_ff   <= upper_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
      cnt_out_ff <= cnt_out_in;
   end

   // result register
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = i2a_pkg::RSP_DATA_W'({cnt_out_ff, char_ff});

endmodule

`default_nettype wire

// ----- sv/integer_to_ascii_digits.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_digits: binary to ascii decimal / hex converter
// Streams out the ascii digits of one value per request, most significant
// first, without leading zeros or prefix.
// ----------------------------------------------------------------------------
// Each request transfer carries a 64-bit value (req_tdata) and a format code
// (req_tuser: 0 decimal, 1 lower-case hex of the low 32 bits, 2 upper-case hex
// of the low 32 bits, 3 lower-case hex of 64 bits). The response stream gives
// one character per transfer; rsp_tlast marks the final digit, which also
// carries the digit count. Requests go through a two-entry queue, so up to
// two may be accepted while the digit engine is busy. The engine handles one
// value at a time: it takes the job, runs one double dabble step per operand
// bit for a decimal value or loads the nibbles directly for a hex value, skips
// the leading zeros, then emits the digits. Response back-pressure adds to the
// emit phase only.
`default_nettype none

module integer_to_ascii_digits (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [i2a_pkg::REQ_DATA_W-1:0] req_tdata,   // [63:0] value
   input  wire logic [i2a_pkg::REQ_USER_W-1:0] req_tuser,   // [1:0] opcode
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [i2a_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [7:0] digit_char,
                                                            // [12:8] digit_count
   output logic                                rsp_tlast    // last_digit
);

   logic             job_valid;
   logic             job_ready;
   i2a_pkg::job_type job;

   // request side and job queue
   i2a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job)
   );

   // digit engine and response register
   i2a_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
